FILE: sv/rlic_pkg.sv
// Package for the route load insertion check block.
// Holds sizes, opcodes and the request/result/command types. No dependencies.
package rlic_pkg;

  localparam int NumLocations = 128;
  localparam int MaxRouteLen  = 64;
  localparam int NumRoutes    = 32;

  localparam int LocW   = $clog2(NumLocations);
  localparam int PosW   = $clog2(MaxRouteLen);
  localparam int LenW   = PosW + 1;
  localparam int RteW   = $clog2(NumRoutes);
  localparam int LoadW  = 24;
  localparam int CapW   = 23;
  localparam int NodeW  = RteW + PosW;
  localparam int TabW   = 2 * LocW;

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpClear  = 2'd1;
  localparam logic [1:0] OpCheck  = 2'd2;

  localparam logic signed [LoadW-1:0] LoadMax = 24'sh7FFFFF;
  localparam logic signed [LoadW-1:0] LoadMin = 24'sh800000;

  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         route_index;
    logic [6:0]         location_id;
    logic signed [15:0] node_demand;
    logic               node_last;
    logic [6:0]         pickup_position;
    logic [6:0]         delivery_position;
    logic signed [15:0] pair_demand;
  } req_t;

  typedef struct packed {
    logic feasible;
    logic route_full;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch_req;     // capture the request, read length
    logic do_append;     // write node, bump length
    logic do_clear;
    logic sum_start;     // reset running sum, i = 0
    logic sum_step;      // issue node read at i
    logic sum_acc;       // accumulate read data at i
    logic row_start;     // i = 0 for table rows
    logic col_start;     // j = i, best init
    logic col_step;      // read at j
    logic col_write;     // update best, write table (j), j++
    logic row_next;      // i++
    logic chk_rd1;       // read node at pickup
    logic chk_rd2;       // read node at delivery
    logic chk_rd3;       // read table
    logic chk_done;      // compute verdict
    logic res_load;      // load result register
  } cmd_t;

  typedef struct packed {
    logic full;          // route length at max
    logic last;          // node_last on request
    logic [1:0] op;
    logic sum_end;       // i reached length
    logic row_end;       // i reached length
    logic col_end;       // j reached length
  } sts_t;

endpackage

FILE: sv/route_load_insertion_check_top.sv
// Top level of the route load insertion check block.
// Instantiates rlic_ctrl and rlic_dp; holds the APB register and result handshake.
//
// Usage: requests enter on in_valid_i/in_stall_o with an rlic_pkg::req_t payload.
// Every request gives exactly one result on out_valid_o/out_stall_i as an
// rlic_pkg::rsp_t. Capacity is written over the APB port at address 0.
// A clear, an unused code or an append without the last mark go straight to the
// result; a check first reads the pickup node, the delivery node and the table.
// An append marked last also refreshes the load table for its route, which is
// written through the single table memory write port.
// One request is in flight at a time; the next is taken once the result is
// loaded.
// Reset: route lengths go to zero and the capacity to 100. A clearing pass
// then zeroes the 16384 load table entries, one entry a cycle; no request is
// accepted during it, while register writes are.
// A stalled result stays in the output register; the block finishes the
// current request and holds until the result is taken.
module route_load_insertion_check_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rlic_pkg::req_t        in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rlic_pkg::rsp_t        out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  rlic_pkg::cmd_t cmd;
  rlic_pkg::sts_t sts;
  logic [rlic_pkg::CapW-1:0] cap_q;
  logic out_valid_q;
  logic ctrl_stall;
  logic [rlic_pkg::TabW:0] clr_cnt_q;
  logic clearing;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {9'd0, cap_q} : 32'd0;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= rlic_pkg::CapW'(100);
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      cap_q <= pwdata[rlic_pkg::CapW-1:0];
    end
  end

  // Mirror of the table clearing pass, used to hold off requests.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end
  assign clearing = !clr_cnt_q[rlic_pkg::TabW];

  assign in_stall_o = ctrl_stall || clearing;

  rlic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i && !clearing),
    .in_stall_o (ctrl_stall),
    .out_busy_i (out_valid_q && out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlic_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .cap_i  (cap_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_data_o)
  );

  // Result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/rlic_ctrl.sv
// Controller for the route load insertion check block.
// Sequences append, refresh, clear and check. Uses rlic_pkg.
module rlic_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            out_busy_i,
  input  rlic_pkg::sts_t  sts_i,
  output rlic_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SDec    = 4'd1;
  localparam logic [3:0] SSumRd  = 4'd2;
  localparam logic [3:0] SSumAcc = 4'd3;
  localparam logic [3:0] SRow    = 4'd4;
  localparam logic [3:0] SColRd  = 4'd5;
  localparam logic [3:0] SColWr  = 4'd6;
  localparam logic [3:0] SChk1   = 4'd7;
  localparam logic [3:0] SChk2   = 4'd8;
  localparam logic [3:0] SChk3   = 4'd9;
  localparam logic [3:0] SChk4   = 4'd10;
  localparam logic [3:0] SDone   = 4'd11;
  localparam logic [3:0] SSumSt  = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d = SDec;
        end
      end
      SDec: begin
        if (sts_i.op == rlic_pkg::OpAppend) begin
          if (!sts_i.full) cmd_o.do_append = 1'b1;
          state_d = sts_i.last ? SSumSt : SDone;
        end else if (sts_i.op == rlic_pkg::OpClear) begin
          cmd_o.do_clear = 1'b1;
          state_d = SDone;
        end else if (sts_i.op == rlic_pkg::OpCheck) begin
          cmd_o.chk_rd1 = 1'b1;
          state_d = SChk1;
        end else begin
          state_d = SDone;
        end
      end
      SSumSt: begin
        cmd_o.sum_start = 1'b1;
        state_d = SSumRd;
      end
      SSumRd: begin
        if (sts_i.sum_end) begin
          cmd_o.row_start = 1'b1;
          state_d = SRow;
        end else begin
          cmd_o.sum_step = 1'b1;
          state_d = SSumAcc;
        end
      end
      SSumAcc: begin
        cmd_o.sum_acc = 1'b1;
        state_d = SSumRd;
      end
      SRow: begin
        if (sts_i.row_end) begin
          state_d = SDone;
        end else begin
          cmd_o.col_start = 1'b1;
          state_d = SColRd;
        end
      end
      SColRd: begin
        if (sts_i.col_end) begin
          cmd_o.row_next = 1'b1;
          state_d = SRow;
        end else begin
          cmd_o.col_step = 1'b1;
          state_d = SColWr;
        end
      end
      SColWr: begin
        cmd_o.col_write = 1'b1;
        state_d = SColRd;
      end
      SChk1: begin
        cmd_o.chk_rd2 = 1'b1;
        state_d = SChk2;
      end
      SChk2: begin
        cmd_o.chk_rd3 = 1'b1;
        state_d = SChk3;
      end
      SChk3: begin
        state_d = SChk4;
      end
      SChk4: begin
        cmd_o.chk_done = 1'b1;
        state_d = SDone;
      end
      SDone: begin
        if (!out_busy_i) begin
          cmd_o.res_load = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

FILE: sv/rlic_dp.sv
// Datapath for the route load insertion check block: route memories,
// running sums, max-load table and verdict. Uses rlic_pkg.
module rlic_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rlic_pkg::req_t                    req_i,
  input  logic [rlic_pkg::CapW-1:0]         cap_i,
  input  rlic_pkg::cmd_t                    cmd_i,
  output rlic_pkg::sts_t                    sts_o,
  output rlic_pkg::rsp_t                    rsp_o
);

  localparam int NodeDepth = rlic_pkg::NumRoutes * rlic_pkg::MaxRouteLen;
  localparam int TabDepth  = rlic_pkg::NumLocations * rlic_pkg::NumLocations;
  localparam int LoadW     = rlic_pkg::LoadW;
  localparam int PosW      = rlic_pkg::PosW;
  localparam int LenW      = rlic_pkg::LenW;
  localparam int RteW      = rlic_pkg::RteW;
  localparam int LocW      = rlic_pkg::LocW;

  // Memories.
  logic [LocW-1:0]         nodes_mem [NodeDepth];
  logic signed [15:0]      loads_mem [NodeDepth];
  logic signed [LoadW-1:0] run_mem   [rlic_pkg::MaxRouteLen];
  logic signed [LoadW-1:0] tab_mem   [TabDepth];

  // Route lengths.
  logic [LenW-1:0]         len_q [rlic_pkg::NumRoutes];

  rlic_pkg::req_t          req_q;
  logic [RteW-1:0]         rte;
  logic [LenW-1:0]         len_cur;
  logic [LenW-1:0]         i_q, j_q;
  logic signed [LoadW-1:0] sum_q, best_q;
  logic [LocW-1:0]         node_rd_q, from_q;
  logic signed [15:0]      load_rd_q;
  logic signed [LoadW-1:0] run_rd_q, tab_rd_q;
  logic [LocW-1:0]         a_q;
  logic                    feas_q, full_q;
  rlic_pkg::rsp_t          rsp_q;

  // Table clear: the table memory has no reset, so a sweep after reset zeroes it.
  logic [rlic_pkg::TabW:0] clr_q;
  logic                    clr_busy;

  assign rte     = req_q.route_index[RteW-1:0];
  assign len_cur = len_q[rte];
  assign clr_busy = !clr_q[rlic_pkg::TabW];

  assign sts_o.full    = (len_cur == LenW'(rlic_pkg::MaxRouteLen));
  assign sts_o.last    = req_q.node_last;
  assign sts_o.op      = req_q.operation;
  assign sts_o.sum_end = (i_q == len_cur);
  assign sts_o.row_end = (i_q == len_cur);
  assign sts_o.col_end = (j_q == len_cur);
  assign rsp_o = rsp_q;

  // Saturating sum of running load and node demand.
  logic signed [LoadW:0] sum_wide;
  logic signed [LoadW-1:0] sum_sat;
  assign sum_wide = {sum_q[LoadW-1], sum_q} + (LoadW+1)'(load_rd_q);
  always_comb begin
    if (sum_wide > (LoadW+1)'(rlic_pkg::LoadMax)) begin
      sum_sat = rlic_pkg::LoadMax;
    end else if (sum_wide < (LoadW+1)'(rlic_pkg::LoadMin)) begin
      sum_sat = rlic_pkg::LoadMin;
    end else begin
      sum_sat = sum_wide[LoadW-1:0];
    end
  end

  // Clamped check positions.
  logic [LenW-1:0] pp_c, dp_c;
  always_comb begin
    pp_c = (LenW'(req_q.pickup_position) >= len_cur) ? len_cur - 1'b1
                                                      : LenW'(req_q.pickup_position);
    dp_c = (LenW'(req_q.delivery_position) >= len_cur) ? len_cur - 1'b1
                                                        : LenW'(req_q.delivery_position);
  end

  // Node memory address mux.
  logic [PosW-1:0] nd_pos;
  always_comb begin
    if (cmd_i.chk_rd1)      nd_pos = pp_c[PosW-1:0];
    else if (cmd_i.chk_rd2) nd_pos = dp_c[PosW-1:0];
    else if (cmd_i.col_step) nd_pos = j_q[PosW-1:0];
    else                    nd_pos = i_q[PosW-1:0];
  end

  // Node and load memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_append) begin
      nodes_mem[{rte, len_cur[PosW-1:0]}] <= req_q.location_id[LocW-1:0];
      loads_mem[{rte, len_cur[PosW-1:0]}] <= req_q.node_demand;
    end
    node_rd_q <= nodes_mem[{rte, nd_pos}];
    load_rd_q <= loads_mem[{rte, nd_pos}];
  end

  // Running load scratch memory; read at j-1 for the column sweep.
  logic [PosW-1:0] run_ra;
  assign run_ra = j_q[PosW-1:0] - 1'b1;
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_acc) run_mem[i_q[PosW-1:0]] <= sum_sat;
    run_rd_q <= run_mem[run_ra];
  end

  // Table memory: clear sweep, depot row, pair rows, check read.
  // The first column of a row starts from the load before that position.
  logic                  tab_we;
  logic [rlic_pkg::TabW-1:0] tab_wa;
  logic signed [LoadW-1:0]   tab_wd, best_nx;
  always_comb begin
    best_nx = best_q;
    if (j_q == i_q) begin
      best_nx = (j_q == '0) ? '0 : run_rd_q;
    end else if (run_rd_q > best_q) begin
      best_nx = run_rd_q;
    end
    tab_we = 1'b0;
    tab_wa = {from_q, node_rd_q};
    tab_wd = best_nx;
    if (clr_busy) begin
      tab_we = 1'b1;
      tab_wa = clr_q[rlic_pkg::TabW-1:0];
      tab_wd = '0;
    end else if (cmd_i.sum_acc) begin
      tab_we = 1'b1;
      tab_wa = {{LocW{1'b0}}, node_rd_q};
      tab_wd = (i_q == '0) ? '0 : sum_q;
    end else if (cmd_i.col_write) begin
      tab_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    if (cmd_i.chk_rd3) tab_rd_q <= tab_mem[{a_q, node_rd_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clr_busy) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Route lengths.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < rlic_pkg::NumRoutes; k++) len_q[k] <= '0;
    end else if (cmd_i.do_append) begin
      len_q[rte] <= len_cur + 1'b1;
    end else if (cmd_i.do_clear) begin
      len_q[rte] <= '0;
    end
  end

  // Check load: table entry plus pair demand.
  logic signed [LoadW+1:0] chk_ld;
  assign chk_ld = (LoadW+2)'(tab_rd_q) + (LoadW+2)'(req_q.pair_demand);

  // Request, counters and accumulators.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) req_q <= req_i;
    if (cmd_i.sum_start) begin
      i_q   <= '0;
      sum_q <= '0;
    end
    if (cmd_i.sum_acc) begin
      sum_q <= sum_sat;
      i_q   <= i_q + 1'b1;
    end
    if (cmd_i.row_start) i_q <= '0;
    if (cmd_i.row_next) i_q <= i_q + 1'b1;
    if (cmd_i.col_start) begin
      j_q    <= i_q;
      best_q <= '0;
    end
    if (cmd_i.col_step && j_q == i_q) from_q <= nodes_mem[{rte, j_q[PosW-1:0]}];
    if (cmd_i.col_write) begin
      best_q <= best_nx;
      j_q    <= j_q + 1'b1;
    end
    if (cmd_i.chk_rd2) a_q <= node_rd_q;
    if (cmd_i.chk_done) begin
      if (req_q.pickup_position > req_q.delivery_position) begin
        feas_q <= 1'b0;
      end else if (len_cur == '0) begin
        feas_q <= ((LoadW+2)'(req_q.pair_demand) <= $signed({3'b000, cap_i}));
      end else begin
        feas_q <= (chk_ld <= $signed({3'b000, cap_i}));
      end
    end
    // An append finds its route full before anything is written.
    if (cmd_i.latch_req) begin
      feas_q <= 1'b0;
      full_q <= (req_i.operation == rlic_pkg::OpAppend) &&
                (len_q[req_i.route_index[RteW-1:0]] == LenW'(rlic_pkg::MaxRouteLen));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      rsp_q.feasible   <= (req_q.operation == rlic_pkg::OpCheck) ? feas_q : 1'b0;
      rsp_q.route_full <= full_q;
    end
  end

endmodule
